### hdl/dv_cip_transmit_pacer_macros.svh
// Assertion macros shared by the transmit pacer modules.
// Users must have clk_i and rst_ni in scope.
`ifndef DV_CIP_TRANSMIT_PACER_MACROS_SVH
`define DV_CIP_TRANSMIT_PACER_MACROS_SVH

// Checked on every rising edge outside reset.
`define DVP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DVP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/dvp_pkg.sv
// Types and constants for the DV CIP transmit pacer.
// No dependencies; used by every module of the block.
package dvp_pkg;

  localparam int unsigned NumWidth    = 12;
  localparam int unsigned PeriodWidth = 10;
  localparam int unsigned OffsetWidth = 4;
  localparam int unsigned CycleWidth  = 13;
  localparam int unsigned DropWidth   = 16;
  localparam int unsigned StampWidth  = 16;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned BytesWidth  = 13;
  localparam int unsigned SumWidth    = 32;

  localparam logic [NumWidth-1:0]    NumeratorReset   = 12'd1;
  localparam logic [NumWidth-1:0]    DenominatorReset = 12'd16;
  localparam logic [PeriodWidth-1:0] PeriodReset      = 10'd300;
  localparam logic [OffsetWidth-1:0] OffsetReset      = 4'd3;

  localparam logic [StampWidth-1:0]  NoStamp     = 16'hFFFF;
  localparam int unsigned            HeaderBytes = 8;

  typedef enum logic [1:0] {
    RegNumerator   = 2'd0,
    RegDenominator = 2'd1,
    RegPeriod      = 2'd2,
    RegOffset      = 2'd3
  } dvp_reg_e;

  typedef struct packed {
    logic [NumWidth-1:0]    numerator;
    logic [NumWidth-1:0]    denominator;
    logic [PeriodWidth-1:0] period;
    logic [OffsetWidth-1:0] offset;
  } dvp_cfg_t;

  typedef struct packed {
    logic [StampWidth-1:0] stamp;
    logic [CountWidth-1:0] block_count;
    logic                  has_data;
    logic [BytesWidth-1:0] packet_bytes;
    logic [SumWidth-1:0]   dropped_sum;
  } dvp_result_t;

endpackage

### hdl/dvp_apb_regs.sv
// APB register file holding the pacing and timestamp configuration.
// Depends on dvp_pkg.
module dvp_apb_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output dvp_pkg::dvp_cfg_t cfg_o
);

  dvp_pkg::dvp_cfg_t cfg_q, cfg_d;
  dvp_pkg::dvp_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = dvp_pkg::dvp_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        dvp_pkg::RegNumerator:   cfg_d.numerator   = pwdata[dvp_pkg::NumWidth-1:0];
        dvp_pkg::RegDenominator: cfg_d.denominator = pwdata[dvp_pkg::NumWidth-1:0];
        dvp_pkg::RegPeriod:      cfg_d.period      = pwdata[dvp_pkg::PeriodWidth-1:0];
        dvp_pkg::RegOffset:      cfg_d.offset      = pwdata[dvp_pkg::OffsetWidth-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dvp_pkg::RegNumerator:   prdata = 32'(cfg_q.numerator);
      dvp_pkg::RegDenominator: prdata = 32'(cfg_q.denominator);
      dvp_pkg::RegPeriod:      prdata = 32'(cfg_q.period);
      dvp_pkg::RegOffset:      prdata = 32'(cfg_q.offset);
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numerator   <= dvp_pkg::NumeratorReset;
      cfg_q.denominator <= dvp_pkg::DenominatorReset;
      cfg_q.period      <= dvp_pkg::PeriodReset;
      cfg_q.offset      <= dvp_pkg::OffsetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/dvp_pace_core.sv
// Pacing decision, timestamp and counters for one packet slot.
// Depends on dvp_pkg and dv_cip_transmit_pacer_macros.svh.
`include "dv_cip_transmit_pacer_macros.svh"

module dvp_pace_core #(
  parameter int unsigned BLOCK_BYTES = 480
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  dvp_pkg::dvp_cfg_t                cfg_i,
  input  logic [dvp_pkg::CycleWidth-1:0]   bus_cycle_i,
  input  logic [dvp_pkg::DropWidth-1:0]    dropped_count_i,
  output dvp_pkg::dvp_result_t             res_o
);

  localparam logic [dvp_pkg::BytesWidth-1:0] DataBytes =
    dvp_pkg::BytesWidth'(dvp_pkg::HeaderBytes + BLOCK_BYTES);
  localparam logic [dvp_pkg::BytesWidth-1:0] EmptyBytes =
    dvp_pkg::BytesWidth'(dvp_pkg::HeaderBytes);

  logic [dvp_pkg::NumWidth-1:0]    acc_q, acc_d;
  logic [dvp_pkg::CountWidth-1:0]  cont_q, cont_d;
  logic [dvp_pkg::PeriodWidth-1:0] pos_q, pos_d;
  logic [dvp_pkg::SumWidth-1:0]    total_q, total_d;

  logic [dvp_pkg::NumWidth-1:0]    gap;
  logic [dvp_pkg::PeriodWidth:0]   pos_next;
  logic [dvp_pkg::OffsetWidth-1:0] stamp_nib;
  logic                            has_data;

  always_comb begin
    gap       = cfg_i.denominator - cfg_i.numerator;
    stamp_nib = bus_cycle_i[dvp_pkg::OffsetWidth-1:0] + cfg_i.offset;
    pos_next  = {1'b0, pos_q} + 1'b1;

    acc_d = acc_q;
    if (cfg_i.numerator >= cfg_i.denominator) begin
      has_data = 1'b1;
    end else if (acc_q > gap) begin
      has_data = 1'b0;
      acc_d    = acc_q - gap;
    end else begin
      has_data = 1'b1;
      acc_d    = acc_q + cfg_i.numerator;
    end

    cont_d = cont_q;
    pos_d  = pos_q;
    if (has_data) begin
      cont_d = cont_q + 1'b1;
      pos_d  = (pos_next >= {1'b0, cfg_i.period}) ? '0 : pos_next[dvp_pkg::PeriodWidth-1:0];
    end

    total_d = total_q + dvp_pkg::SumWidth'(dropped_count_i);

    res_o.stamp        = (pos_q == '0) ? {stamp_nib, 12'h000} : dvp_pkg::NoStamp;
    res_o.block_count  = cont_q;
    res_o.has_data     = has_data;
    res_o.packet_bytes = has_data ? DataBytes : EmptyBytes;
    res_o.dropped_sum  = total_d;
  end

  // Commit state only when the slot moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cont_q  <= '0;
      pos_q   <= '0;
      total_q <= '0;
    end else if (advance_i) begin
      acc_q   <= acc_d;
      cont_q  <= cont_d;
      pos_q   <= pos_d;
      total_q <= total_d;
    end
  end

  `DVP_ASSERT(a_acc_hold_full_rate,
    advance_i && (cfg_i.numerator >= cfg_i.denominator) |=> $stable(acc_q),
    "rate accumulator moved while every slot carries data")
  `DVP_ASSERT(a_empty_keeps_counters,
    advance_i && !res_o.has_data |=> $stable(cont_q) && $stable(pos_q),
    "empty packet changed continuity or period position")
  `DVP_ASSERT(a_stamp_only_at_period_start,
    res_o.stamp != dvp_pkg::NoStamp |-> pos_q == '0,
    "timestamp issued away from period start")

endmodule

### hdl/dv_cip_transmit_pacer.sv
// DV CIP transmit pacer: one input slot per bus cycle, one packet descriptor out.
// Channels: s_axis carries {dropped_count, bus_cycle}; m_axis carries the packet
// descriptor (stamp, block_count, packet_bytes, dropped_sum in tdata, has_data
// in tuser). APB port sets numerator, denominator, stamp period and offset.
// A transaction accepted on s_axis passes the input register, then the result
// register, before it is presented on m_axis. Throughput: one transaction per
// cycle unless the receiver stalls; one pass of decision logic between registers.
// Reset restores PAL defaults (1/16, period 300, offset 3) and clears the
// accumulator, continuity counter, period position and dropped total.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; s_axis_tready drops only when both are
// full. Depends on dvp_pkg, dvp_apb_regs, dvp_pace_core and the macro header.
`include "dv_cip_transmit_pacer_macros.svh"

module dv_cip_transmit_pacer #(
  parameter int unsigned BLOCK_BYTES = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [12:0] bus_cycle, [28:13] dropped_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] stamp, [23:16] block_count,
                                      // [36:24] packet_bytes, [68:37] dropped_sum
  output logic        m_axis_tuser,   // [0] has_data
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CycLsb  = 0;
  localparam int unsigned DropLsb = CycLsb + dvp_pkg::CycleWidth;

  dvp_pkg::dvp_cfg_t    cfg;
  dvp_pkg::dvp_result_t res;

  logic                           in_valid_q, in_valid_d;
  logic [dvp_pkg::CycleWidth-1:0] in_cycle_q;
  logic [dvp_pkg::DropWidth-1:0]  in_drop_q;
  logic                           out_valid_q, out_valid_d;
  dvp_pkg::dvp_result_t           out_res_q;
  logic                           advance;
  logic                           in_take;

  dvp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dvp_pace_core #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .cfg_i           (cfg),
    .bus_cycle_i     (in_cycle_q),
    .dropped_count_i (in_drop_q),
    .res_o           (res)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transaction, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cycle_q <= s_axis_tdata[DropLsb-1:CycLsb];
      in_drop_q  <= s_axis_tdata[DropLsb+dvp_pkg::DropWidth-1:DropLsb];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.has_data;
  assign m_axis_tdata  = {3'b000, out_res_q.dropped_sum, out_res_q.packet_bytes,
                          out_res_q.block_count, out_res_q.stamp};

  `DVP_ASSERT(a_no_overwrite,
    out_valid_q && !m_axis_tready |-> !advance,
    "result register overwritten while stalled")
  `DVP_ASSERT(a_input_held,
    in_valid_q && !advance |=> in_valid_q,
    "pending input slot lost")
  `DVP_ASSERT_ALWAYS(a_bytes_match_flag,
    !m_axis_tvalid || (out_res_q.packet_bytes ==
      (out_res_q.has_data ? dvp_pkg::BytesWidth'(dvp_pkg::HeaderBytes + BLOCK_BYTES)
                          : dvp_pkg::BytesWidth'(dvp_pkg::HeaderBytes))),
    "packet length disagrees with data flag")

endmodule
